[hdl/gffr_pkg.sv]
// Package for the grid flood-fill reach counter: sizes, field codes, queue entry layout,
// sequencer state encoding and the grid size clamp.
// Depends on nothing; used by gffr_ram users and grid_flood_fill_reach_count.
package gffr_pkg;

    // Grid capacity.
    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int CELL_CAP = MAX_COLS * MAX_ROWS;

    // Derived widths.
    localparam int IDX_W   = $clog2(CELL_CAP);
    localparam int CNT_W   = IDX_W + 1;
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COLS_W  = $clog2(MAX_COLS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int SIZE_W  = 7;
    localparam int QENT_W  = IDX_W + ROW_W + COL_W;
    localparam int DIV_STEPS = IDX_W;
    localparam int DCNT_W  = $clog2(DIV_STEPS);

    // Stream widths.
    localparam int KIND_W    = 2;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 16;
    localparam int CFG_IDX_W = 1;

    // Reset values of the size registers.
    localparam logic [SIZE_W-1:0] COLS_RST = SIZE_W'(64);
    localparam logic [SIZE_W-1:0] ROWS_RST = SIZE_W'(64);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b1;

    // Cell kind codes.
    localparam logic [KIND_W-1:0] KIND_WALL  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    // One frontier queue entry: linear index plus its row and column.
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } q_entry_t;

    // Sequencer states.
    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_DIV   = 7'b0000010,
        ST_INIT  = 7'b0000100,
        ST_POP   = 7'b0001000,
        ST_FETCH = 7'b0010000,
        ST_NBR   = 7'b0100000,
        ST_DONE  = 7'b1000000
    } state_t;

    // Neighbour visiting order; NB_END only drains the last check.
    typedef enum logic [2:0] {
        NB_UP    = 3'd0,
        NB_RIGHT = 3'd1,
        NB_DOWN  = 3'd2,
        NB_LEFT  = 3'd3,
        NB_END   = 3'd4
    } nbr_t;

    // A size of zero acts as one; anything above the maximum saturates.
    function automatic int clamp_size(input int v, input int maxv);
        int r;
        if (v == 0) begin
            r = 1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

[hdl/gffr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the open map and the frontier queue.
module gffr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hdl/grid_flood_fill_reach_count.sv]
// Top level of the grid flood-fill reach counter: load sequencer, seed divider and
// breadth-first fill sequencer. Depends on gffr_pkg and gffr_ram.
//
// Cells are taken one beat per cycle in row-major order; a beat with tlast ends the grid.
// After that beat the input stalls while the fill runs: the seed index is split into
// row and column by a shift-subtract divider, then the seed entry is written to the queue,
// then every reachable cell is handled by a queue read, an entry latch and four neighbour
// probes pipelined through the single read port of the open-map RAM; the fill ends when
// the queue is found empty, and then the result is posted. A job with no usable start
// marker skips the fill. The result waits in an output register, so loading of the
// next grid goes on while it is unclaimed. Visited cells are marked by clearing their
// open bit, so no clearing pass is ever needed after reset or between jobs.
module grid_flood_fill_reach_count (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // Cell input: tdata = cell_kind; tlast = last_cell.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [gffr_pkg::S_DATA_W-1:0]        s_tdata,
    input  logic                                 s_tlast,
    // Result: tdata = reachable_count; tuser = start_found.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [gffr_pkg::M_DATA_W-1:0]        m_tdata,
    output logic                                 m_tuser,
    // Size register writes.
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [gffr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gffr_pkg::SIZE_W-1:0]          cfg_data
);

    localparam int IDX_W  = gffr_pkg::IDX_W;
    localparam int CNT_W  = gffr_pkg::CNT_W;
    localparam int COL_W  = gffr_pkg::COL_W;
    localparam int ROW_W  = gffr_pkg::ROW_W;
    localparam int COLS_W = gffr_pkg::COLS_W;
    localparam int ROWS_W = gffr_pkg::ROWS_W;

    gffr_pkg::state_t   state_reg, state_next;
    logic [gffr_pkg::SIZE_W-1:0] cols_cfg_reg, cols_cfg_next;
    logic [gffr_pkg::SIZE_W-1:0] rows_cfg_reg, rows_cfg_next;
    logic [CNT_W-1:0]   load_idx_reg, load_idx_next;
    logic [IDX_W-1:0]   seed_idx_reg, seed_idx_next;
    logic               seed_valid_reg, seed_valid_next;
    logic [CNT_W-1:0]   loaded_reg, loaded_next;
    logic [COLS_W-1:0]  rem_reg, rem_next;
    logic [IDX_W-1:0]   quo_reg, quo_next;
    logic [gffr_pkg::DCNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic [CNT_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   tail_reg, tail_next;
    gffr_pkg::q_entry_t cur_reg, cur_next;
    gffr_pkg::nbr_t     nbr_reg, nbr_next;
    logic               cand_valid_reg, cand_valid_next;
    gffr_pkg::q_entry_t cand_reg, cand_next;
    logic               res_found_reg, res_found_next;
    logic               out_valid_reg, out_valid_next;
    logic [CNT_W-1:0]   out_count_reg, out_count_next;
    logic               out_found_reg, out_found_next;

    logic [COLS_W-1:0]  cols_eff;
    logic [ROWS_W-1:0]  rows_eff;
    logic [COLS_W+ROWS_W-1:0] total_prod;
    logic [CNT_W-1:0]   total;
    logic [gffr_pkg::KIND_W-1:0] kind;
    logic               in_acc, in_grid, seed_take;
    logic [IDX_W-1:0]   seed_idx_new;
    logic               seed_valid_new, found_new;
    logic [CNT_W-1:0]   load_new;
    logic [COLS_W:0]    trial;
    logic               trial_ge;
    logic [CNT_W-1:0]   cur_idx_ext, cols_ext, nbr_idx;
    logic               nbr_ok, cand_ok, enq, out_load;
    gffr_pkg::q_entry_t nbr_entry, seed_entry;

    logic                         open_wr_en, open_wr_data, open_rd_en, open_rd_data;
    logic [IDX_W-1:0]             open_wr_addr, open_rd_addr;
    logic                         q_wr_en, q_rd_en;
    logic [IDX_W-1:0]             q_wr_addr, q_rd_addr;
    logic [gffr_pkg::QENT_W-1:0]  q_wr_data, q_rd_data;

    // Effective grid size and cell total.
    assign cols_eff   = COLS_W'(gffr_pkg::clamp_size(int'(cols_cfg_reg), gffr_pkg::MAX_COLS));
    assign rows_eff   = ROWS_W'(gffr_pkg::clamp_size(int'(rows_cfg_reg), gffr_pkg::MAX_ROWS));
    assign total_prod = (COLS_W+ROWS_W)'(cols_eff) * (COLS_W+ROWS_W)'(rows_eff);
    assign total      = total_prod[CNT_W-1:0];

    // Load side: store the open bit and catch the first start marker.
    assign kind           = s_tdata[gffr_pkg::KIND_W-1:0];
    assign s_tready       = (state_reg == gffr_pkg::ST_LOAD);
    assign in_acc         = s_tvalid && s_tready;
    assign in_grid        = (load_idx_reg < total);
    assign seed_take      = in_grid && (kind == gffr_pkg::KIND_START) && !seed_valid_reg;
    assign seed_idx_new   = seed_take ? load_idx_reg[IDX_W-1:0] : seed_idx_reg;
    assign seed_valid_new = seed_valid_reg || seed_take;
    assign found_new      = seed_valid_new && ({1'b0, seed_idx_new} < total);
    assign load_new       = load_idx_reg + CNT_W'(in_grid);

    // Shift-subtract step of the seed divider (quotient is the row, remainder the column).
    assign trial    = {rem_reg, quo_reg[IDX_W-1]};
    assign trial_ge = (trial >= (COLS_W+1)'(cols_eff));

    assign seed_entry.idx = seed_idx_reg;
    assign seed_entry.row = quo_reg[ROW_W-1:0];
    assign seed_entry.col = rem_reg[COL_W-1:0];

    // Neighbour candidate for the current probe.
    assign cur_idx_ext = CNT_W'(cur_reg.idx);
    assign cols_ext    = CNT_W'(cols_eff);

    always_comb begin
        nbr_ok        = 1'b0;
        nbr_idx       = cur_idx_ext;
        nbr_entry.row = cur_reg.row;
        nbr_entry.col = cur_reg.col;
        case (nbr_reg)
            gffr_pkg::NB_UP: begin
                nbr_ok        = (cur_reg.row != '0);
                nbr_idx       = cur_idx_ext - cols_ext;
                nbr_entry.row = cur_reg.row - 1'b1;
            end
            gffr_pkg::NB_RIGHT: begin
                nbr_ok        = ((COLS_W'(cur_reg.col) + 1'b1) < cols_eff);
                nbr_idx       = cur_idx_ext + 1'b1;
                nbr_entry.col = cur_reg.col + 1'b1;
            end
            gffr_pkg::NB_DOWN: begin
                nbr_ok        = ((ROWS_W'(cur_reg.row) + 1'b1) < rows_eff);
                nbr_idx       = cur_idx_ext + cols_ext;
                nbr_entry.row = cur_reg.row + 1'b1;
            end
            gffr_pkg::NB_LEFT: begin
                nbr_ok        = (cur_reg.col != '0);
                nbr_idx       = cur_idx_ext - 1'b1;
                nbr_entry.col = cur_reg.col - 1'b1;
            end
            default: begin
                nbr_ok = 1'b0;
            end
        endcase
        nbr_entry.idx = nbr_idx[IDX_W-1:0];
    end

    assign cand_ok = (state_reg == gffr_pkg::ST_NBR) && nbr_ok && (nbr_idx < loaded_reg);

    // A probed neighbour that is still open is enqueued and its open bit cleared.
    assign enq = (state_reg == gffr_pkg::ST_NBR) && cand_valid_reg && open_rd_data;

    // Open map ports.
    assign open_wr_en   = (in_acc && in_grid) || enq;
    assign open_wr_addr = (state_reg == gffr_pkg::ST_LOAD) ? load_idx_reg[IDX_W-1:0]
                                                           : cand_reg.idx;
    assign open_wr_data = (state_reg == gffr_pkg::ST_LOAD) && (kind == gffr_pkg::KIND_OPEN);
    assign open_rd_en   = cand_ok;
    assign open_rd_addr = nbr_entry.idx;

    // Frontier queue ports.
    assign q_wr_en   = enq || (state_reg == gffr_pkg::ST_INIT);
    assign q_wr_addr = (state_reg == gffr_pkg::ST_INIT) ? '0 : tail_reg[IDX_W-1:0];
    assign q_wr_data = (state_reg == gffr_pkg::ST_INIT) ? seed_entry : cand_reg;
    assign q_rd_en   = (state_reg == gffr_pkg::ST_POP) && (head_reg != tail_reg);
    assign q_rd_addr = head_reg[IDX_W-1:0];

    gffr_ram #(.WIDTH(1), .DEPTH(gffr_pkg::CELL_CAP)) u_open_map (
        .aclk    (aclk),
        .wr_en   (open_wr_en),
        .wr_addr (open_wr_addr),
        .wr_data (open_wr_data),
        .rd_en   (open_rd_en),
        .rd_addr (open_rd_addr),
        .rd_data (open_rd_data)
    );

    gffr_ram #(.WIDTH(gffr_pkg::QENT_W), .DEPTH(gffr_pkg::CELL_CAP)) u_frontier (
        .aclk    (aclk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    // Result register handshake.
    assign out_load = (state_reg == gffr_pkg::ST_DONE) && (!out_valid_reg || m_tready);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = gffr_pkg::M_DATA_W'(out_count_reg);
    assign m_tuser  = out_found_reg;
    assign cfg_ready = 1'b1;

    // Sequencer and datapath next values.
    always_comb begin
        state_next      = state_reg;
        cols_cfg_next   = cols_cfg_reg;
        rows_cfg_next   = rows_cfg_reg;
        load_idx_next   = load_idx_reg;
        seed_idx_next   = seed_idx_reg;
        seed_valid_next = seed_valid_reg;
        loaded_next     = loaded_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cur_next        = cur_reg;
        nbr_next        = nbr_reg;
        cand_valid_next = cand_valid_reg;
        cand_next       = cand_reg;
        res_found_next  = res_found_reg;
        out_valid_next  = out_valid_reg;
        out_count_next  = out_count_reg;
        out_found_next  = out_found_reg;

        if (cfg_valid && cfg_ready) begin
            if (cfg_index == gffr_pkg::REG_GRID_COLS) begin
                cols_cfg_next = cfg_data;
            end else begin
                rows_cfg_next = cfg_data;
            end
        end

        case (state_reg)
            gffr_pkg::ST_LOAD: begin
                if (in_acc) begin
                    load_idx_next   = load_new;
                    seed_idx_next   = seed_idx_new;
                    seed_valid_next = seed_valid_new;
                    if (s_tlast) begin
                        load_idx_next   = '0;
                        seed_valid_next = 1'b0;
                        loaded_next     = (load_new < total) ? load_new : total;
                        res_found_next  = found_new;
                        rem_next        = '0;
                        quo_next        = seed_idx_new;
                        div_cnt_next    = '0;
                        state_next      = found_new ? gffr_pkg::ST_DIV : gffr_pkg::ST_DONE;
                    end
                end
            end
            gffr_pkg::ST_DIV: begin
                rem_next     = trial_ge ? COLS_W'(trial - (COLS_W+1)'(cols_eff))
                                        : trial[COLS_W-1:0];
                quo_next     = {quo_reg[IDX_W-2:0], trial_ge};
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == gffr_pkg::DCNT_W'(gffr_pkg::DIV_STEPS - 1)) begin
                    state_next = gffr_pkg::ST_INIT;
                end
            end
            gffr_pkg::ST_INIT: begin
                head_next  = '0;
                tail_next  = CNT_W'(1);
                state_next = gffr_pkg::ST_POP;
            end
            gffr_pkg::ST_POP: begin
                if (head_reg == tail_reg) begin
                    state_next = gffr_pkg::ST_DONE;
                end else begin
                    head_next  = head_reg + 1'b1;
                    state_next = gffr_pkg::ST_FETCH;
                end
            end
            gffr_pkg::ST_FETCH: begin
                cur_next        = q_rd_data;
                nbr_next        = gffr_pkg::NB_UP;
                cand_valid_next = 1'b0;
                state_next      = gffr_pkg::ST_NBR;
            end
            gffr_pkg::ST_NBR: begin
                // Probe one neighbour while the previous probe's answer is checked.
                cand_valid_next = cand_ok;
                cand_next       = nbr_entry;
                if (enq) begin
                    tail_next = tail_reg + 1'b1;
                end
                if (nbr_reg == gffr_pkg::NB_END) begin
                    state_next = gffr_pkg::ST_POP;
                end else begin
                    nbr_next = gffr_pkg::nbr_t'(nbr_reg + 1'b1);
                end
            end
            gffr_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = gffr_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = gffr_pkg::ST_LOAD;
            end
        endcase

        // Output register: reload takes precedence over the drain.
        if (out_load) begin
            out_valid_next = 1'b1;
            out_count_next = res_found_reg ? head_reg : '0;
            out_found_next = res_found_reg;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Control registers with reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= gffr_pkg::ST_LOAD;
            cols_cfg_reg   <= gffr_pkg::COLS_RST;
            rows_cfg_reg   <= gffr_pkg::ROWS_RST;
            load_idx_reg   <= '0;
            seed_idx_reg   <= '0;
            seed_valid_reg <= 1'b0;
            head_reg       <= '0;
            tail_reg       <= '0;
            nbr_reg        <= gffr_pkg::NB_UP;
            div_cnt_reg    <= '0;
            cand_valid_reg <= 1'b0;
            res_found_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cols_cfg_reg   <= cols_cfg_next;
            rows_cfg_reg   <= rows_cfg_next;
            load_idx_reg   <= load_idx_next;
            seed_idx_reg   <= seed_idx_next;
            seed_valid_reg <= seed_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            nbr_reg        <= nbr_next;
            div_cnt_reg    <= div_cnt_next;
            cand_valid_reg <= cand_valid_next;
            res_found_reg  <= res_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        loaded_reg    <= loaded_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        cur_reg       <= cur_next;
        cand_reg      <= cand_next;
        out_count_reg <= out_count_next;
        out_found_reg <= out_found_next;
    end

    // The queue never runs dry below its head while a fill is in flight.
    a_head_le_tail: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gffr_pkg::ST_POP || state_reg == gffr_pkg::ST_FETCH ||
         state_reg == gffr_pkg::ST_NBR) |-> (head_reg <= tail_reg))
        else $error("frontier head passed tail");

    // Only loaded cells can ever be enqueued, each once.
    a_tail_le_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == gffr_pkg::ST_POP || state_reg == gffr_pkg::ST_FETCH ||
         state_reg == gffr_pkg::ST_NBR) |-> (tail_reg <= loaded_reg))
        else $error("more cells enqueued than were loaded");

    // The last cell of a grid always stops the loader.
    a_last_leaves_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_tlast) |=> (state_reg != gffr_pkg::ST_LOAD))
        else $error("loader kept running after the last cell");

    // A job without a start marker reports a zero count.
    a_no_start_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_found_reg) |-> (out_count_reg == '0))
        else $error("non-zero count without a start marker");

    // Enqueues happen only while probing neighbours.
    a_enq_in_nbr: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_wr_en && state_reg != gffr_pkg::ST_INIT) |-> (state_reg == gffr_pkg::ST_NBR))
        else $error("queue written outside neighbour probing");

endmodule
